### rtl/lcgkx_pkg.sv
// shared types and constants for the lcg keystream xor cipher
package lcgkx_pkg;

    localparam int STATE_W = 64;
    localparam int HALF_W  = 32;
    localparam int KEEP_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 6;

    localparam logic [INDEX_W-1:0] REG_SEED       = 8'd0;
    localparam logic [INDEX_W-1:0] REG_MODULUS    = 8'd1;
    localparam logic [INDEX_W-1:0] REG_MULTIPLIER = 8'd2;
    localparam logic [INDEX_W-1:0] REG_INCREMENT  = 8'd3;
    localparam logic [INDEX_W-1:0] REG_KEEP_BITS  = 8'd4;

    localparam logic [STATE_W-1:0] SEED_RESET       = 64'd0;
    localparam logic [STATE_W-1:0] MODULUS_RESET    = 64'd2147483648;
    localparam logic [STATE_W-1:0] MULTIPLIER_RESET = 64'd1103515245;
    localparam logic [STATE_W-1:0] INCREMENT_RESET  = 64'd12345;
    localparam logic [KEEP_W-1:0]  KEEP_BITS_RESET  = 6'd32;

    localparam logic [BYTE_W-1:0]  KEY_BYTE_MASK = 8'hFF;
    localparam logic [COUNT_W-1:0] DIV_LAST_STEP = 6'd63;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_ADD,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mod_zero;
    } sts_t;

endpackage

### rtl/lcgkx_if.sv
// channel interfaces for input bytes, result bytes and register writes
interface lcgkx_in_if;
    logic                           valid;
    logic                           ready;
    logic [lcgkx_pkg::BYTE_W-1:0]   in_byte;
    logic                           last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface lcgkx_out_if;
    logic                           valid;
    logic                           ready;
    logic [lcgkx_pkg::BYTE_W-1:0]   out_byte;
    logic                           out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface lcgkx_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lcgkx_pkg::INDEX_W-1:0]  index;
    logic [lcgkx_pkg::STATE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/lcgkx_dp.sv
// datapath: registers, shared 32x32 multiplier, bit-serial remainder unit
module lcgkx_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lcgkx_pkg::cmd_t                cmd,
    output lcgkx_pkg::sts_t                sts,
    input  logic                           cfg_we,
    input  logic [lcgkx_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [lcgkx_pkg::STATE_W-1:0]  cfg_data,
    input  logic [lcgkx_pkg::BYTE_W-1:0]   in_byte,
    input  logic                           in_last,
    output logic [lcgkx_pkg::BYTE_W-1:0]   out_byte,
    output logic                           out_last
);

    logic [lcgkx_pkg::STATE_W-1:0] seed_reg;
    logic [lcgkx_pkg::STATE_W-1:0] modulus_reg;
    logic [lcgkx_pkg::STATE_W-1:0] multiplier_reg;
    logic [lcgkx_pkg::STATE_W-1:0] increment_reg;
    logic [lcgkx_pkg::KEEP_W-1:0]  keep_bits_reg;
    logic [lcgkx_pkg::STATE_W-1:0] gen_state_reg;
    logic                          fresh_reg;

    logic [lcgkx_pkg::STATE_W-1:0] operand_reg;
    logic [lcgkx_pkg::STATE_W-1:0] acc_reg;
    logic [lcgkx_pkg::STATE_W-1:0] dividend_reg;
    logic [lcgkx_pkg::STATE_W-1:0] rem_reg;
    logic [lcgkx_pkg::BYTE_W-1:0]  byte_reg;
    logic                          last_reg;
    logic [lcgkx_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                          out_last_reg;

    logic [lcgkx_pkg::HALF_W-1:0]  mul_a;
    logic [lcgkx_pkg::HALF_W-1:0]  mul_b;
    logic [lcgkx_pkg::STATE_W-1:0] product;
    logic [lcgkx_pkg::STATE_W:0]   rem_shift;
    logic [lcgkx_pkg::STATE_W:0]   rem_diff;
    logic [lcgkx_pkg::STATE_W-1:0] rem_next;
    logic [lcgkx_pkg::STATE_W-1:0] reduced;
    logic [lcgkx_pkg::STATE_W-1:0] keep_mask;
    logic [lcgkx_pkg::STATE_W-1:0] new_state;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (cmd.op)
            lcgkx_pkg::OP_MUL_LH:
            begin
                mul_a = operand_reg[lcgkx_pkg::HALF_W-1:0];
                mul_b = multiplier_reg[lcgkx_pkg::STATE_W-1:lcgkx_pkg::HALF_W];
            end
            lcgkx_pkg::OP_MUL_HL:
            begin
                mul_a = operand_reg[lcgkx_pkg::STATE_W-1:lcgkx_pkg::HALF_W];
                mul_b = multiplier_reg[lcgkx_pkg::HALF_W-1:0];
            end
            default:
            begin
                mul_a = operand_reg[lcgkx_pkg::HALF_W-1:0];
                mul_b = multiplier_reg[lcgkx_pkg::HALF_W-1:0];
            end
        endcase
    end

    assign product = lcgkx_pkg::STATE_W'(mul_a) * lcgkx_pkg::STATE_W'(mul_b);

    // one restoring division step
    assign rem_shift = {rem_reg, dividend_reg[lcgkx_pkg::STATE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, modulus_reg};
    assign rem_next  = rem_diff[lcgkx_pkg::STATE_W] ? rem_shift[lcgkx_pkg::STATE_W-1:0]
                                                     : rem_diff[lcgkx_pkg::STATE_W-1:0];

    assign reduced   = sts.mod_zero ? dividend_reg : rem_reg;
    assign keep_mask = (keep_bits_reg == '0) ? '0
                     : ((lcgkx_pkg::STATE_W'(1) << keep_bits_reg) - lcgkx_pkg::STATE_W'(1));
    assign new_state = reduced & keep_mask;

    assign sts.mod_zero = (modulus_reg == '0);
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;

    // configuration and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= lcgkx_pkg::SEED_RESET;
            modulus_reg    <= lcgkx_pkg::MODULUS_RESET;
            multiplier_reg <= lcgkx_pkg::MULTIPLIER_RESET;
            increment_reg  <= lcgkx_pkg::INCREMENT_RESET;
            keep_bits_reg  <= lcgkx_pkg::KEEP_BITS_RESET;
            gen_state_reg  <= lcgkx_pkg::SEED_RESET;
            fresh_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lcgkx_pkg::REG_SEED:       seed_reg       <= cfg_data;
                    lcgkx_pkg::REG_MODULUS:    modulus_reg    <= cfg_data;
                    lcgkx_pkg::REG_MULTIPLIER: multiplier_reg <= cfg_data;
                    lcgkx_pkg::REG_INCREMENT:  increment_reg  <= cfg_data;
                    lcgkx_pkg::REG_KEEP_BITS:  keep_bits_reg  <= cfg_data[lcgkx_pkg::KEEP_W-1:0];
                    default:                   ;
                endcase
            end
            if (cmd.op == lcgkx_pkg::OP_LOAD)
            begin
                fresh_reg <= 1'b0;
            end
            else if (cmd.op == lcgkx_pkg::OP_FINISH)
            begin
                gen_state_reg <= new_state;
                fresh_reg     <= last_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            lcgkx_pkg::OP_LOAD:
            begin
                operand_reg <= fresh_reg ? seed_reg : gen_state_reg;
                byte_reg    <= in_byte;
                last_reg    <= in_last;
            end
            lcgkx_pkg::OP_MUL_LL:
            begin
                acc_reg <= product;
            end
            lcgkx_pkg::OP_MUL_LH, lcgkx_pkg::OP_MUL_HL:
            begin
                acc_reg <= acc_reg + {product[lcgkx_pkg::HALF_W-1:0],
                                      lcgkx_pkg::HALF_W'(0)};
            end
            lcgkx_pkg::OP_ADD:
            begin
                dividend_reg <= acc_reg + increment_reg;
                rem_reg      <= '0;
            end
            lcgkx_pkg::OP_DIV_STEP:
            begin
                dividend_reg <= {dividend_reg[lcgkx_pkg::STATE_W-2:0], 1'b0};
                rem_reg      <= rem_next;
            end
            lcgkx_pkg::OP_FINISH:
            begin
                out_byte_reg <= byte_reg ^ (new_state[lcgkx_pkg::BYTE_W-1:0]
                                            & lcgkx_pkg::KEY_BYTE_MASK);
                out_last_reg <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/lcgkx_ctrl.sv
// controller: sequences load, multiply, add, divide and result hand-off
module lcgkx_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output lcgkx_pkg::cmd_t cmd,
    input  lcgkx_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [lcgkx_pkg::COUNT_W-1:0]   count_reg;
    logic [lcgkx_pkg::COUNT_W-1:0]   count_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            finish;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign finish    = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = lcgkx_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = lcgkx_pkg::OP_LOAD;
                    state_next = ST_MUL_LL;
                end
            end
            ST_MUL_LL:
            begin
                cmd.op     = lcgkx_pkg::OP_MUL_LL;
                state_next = ST_MUL_LH;
            end
            ST_MUL_LH:
            begin
                cmd.op     = lcgkx_pkg::OP_MUL_LH;
                state_next = ST_MUL_HL;
            end
            ST_MUL_HL:
            begin
                cmd.op     = lcgkx_pkg::OP_MUL_HL;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.op     = lcgkx_pkg::OP_ADD;
                count_next = '0;
                state_next = sts.mod_zero ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op     = lcgkx_pkg::OP_DIV_STEP;
                count_next = count_reg + lcgkx_pkg::COUNT_W'(1);
                if (count_reg == lcgkx_pkg::DIV_LAST_STEP)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (finish)
                begin
                    cmd.op         = lcgkx_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL_LL))
        else $error("accepted transaction did not start the multiply");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && count_reg == lcgkx_pkg::DIV_LAST_STEP) |=> (state_reg == ST_OUT))
        else $error("division did not end after the last step");

    a_zero_mod_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && sts.mod_zero) |=> (state_reg == ST_OUT))
        else $error("zero modulus did not skip the division");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished transaction not presented");
`endif

endmodule

### rtl/lcg_keystream_xor_cipher.sv
// top level of the lcg keystream xor cipher
//
// in_ch carries one byte per transaction plus a last marker; out_ch returns
// one byte per transaction, the input xored with the low byte of the next
// generator state, with the marker copied. cfg writes the registers by
// index: 0 seed, 1 modulus, 2 multiplier, 3 increment, 4 keep bits;
// other indexes are ignored. cfg is always ready; the user must write it
// only while idle, the block itself does not enforce it. the 64-bit product
// is built from three 32x32 partial products, then the increment is added
// and a restoring divider produces the remainder one bit per cycle; with a
// zero modulus the division is skipped. a new byte is taken only after the
// previous result has moved to the output register.
// a finished result waits in the output register while the next byte is
// taken; if the receiver stalls, the next result holds in the controller
// until the output register frees up. reset loads the register defaults and
// marks the next byte as the start of a message, which restarts from the
// seed; a byte marked last does the same for the byte after it.
module lcg_keystream_xor_cipher (
    input  logic        clk,
    input  logic        rst_n,
    lcgkx_in_if.sink    in_ch,
    lcgkx_out_if.source out_ch,
    lcgkx_cfg_if.sink   cfg
);

    lcgkx_pkg::cmd_t cmd;
    lcgkx_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    lcgkx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lcgkx_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_byte   (in_ch.in_byte),
        .in_last   (in_ch.last),
        .out_byte  (out_ch.out_byte),
        .out_last  (out_ch.out_last)
    );

endmodule
